// ----- hdl/uvsg_pkg.sv -----
// shared types, constants and tables for the uv sphere vertex generator
package uvsg_pkg;

   localparam int ResWidth     = 9;    // effective resolution up to 256
   localparam int MaxRes       = 256;
   localparam int FracBits     = 15;
   localparam int CordicSteps  = 20;
   localparam int StepWidth    = 5;
   localparam logic signed [33:0] CordicInvGain = 34'sd652032874;

   localparam logic signed [15:0] QMax = 16'sh7fff;
   localparam logic signed [15:0] QMin = -16'sh8000;

   // divider command: what the quotient is for
   typedef enum logic [1:0] {
      DIV_PHASE = 2'b00,
      DIV_TEX   = 2'b01
   } div_kind_type;

   // request from sequencer to the divider
   typedef struct packed {
      logic        start;
      logic [40:0] dividend;
      logic [8:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [40:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] phase;
   } cordic_req_type;

   typedef struct packed {
      logic               done;
      logic signed [33:0] cos_val;
      logic signed [33:0] sin_val;
   } cordic_rsp_type;

   // arctangent table in units of 2^-32 turn
   function automatic logic [31:0] atan_phase(input logic [StepWidth-1:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- hdl/uvsg_divider.sv -----
// restoring divider, one quotient bit per cycle
module uvsg_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  uvsg_pkg::div_req_type req,
   output uvsg_pkg::div_rsp_type rsp
);

   logic [40:0] quo_ff, quo_in;
   logic [9:0]  rem_ff, rem_in;
   logic [8:0]  dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [9:0]  trial;

   // shift one dividend bit into the remainder and try a subtract
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[8:0], quo_ff[40]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = 6'd41;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[39:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[39:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- hdl/uvsg_cordic.sv -----
// iterative cordic rotation giving cosine and sine in q30
module uvsg_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  uvsg_pkg::cordic_req_type req,
   output uvsg_pkg::cordic_rsp_type rsp
);

   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [1:0]         q_ff, q_in;
   logic [4:0]         i_ff, i_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [1:0]         quad;
   logic [31:0]        red;
   logic signed [33:0] dx, dy, ang;

   assign quad = 2'((req.phase + 32'h2000_0000) >> 30);
   assign red  = req.phase - {quad, 30'd0};
   assign dx   = y_ff >>> i_ff;
   assign dy   = x_ff >>> i_ff;
   assign ang  = $signed({2'b00, uvsg_pkg::atan_phase(i_ff)});

   // one micro-rotation per cycle
   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; q_in = q_ff; i_in = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         x_in = uvsg_pkg::CordicInvGain;
         y_in = '0;
         z_in = 34'($signed(red));
         q_in = quad;
         i_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + ang;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(uvsg_pkg::CordicSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      q_ff <= q_in; i_ff <= i_in;
   end

   // map back from the reduced quarter
   always_comb begin
      unique case (q_ff)
         2'd0: begin rsp.cos_val = x_ff;  rsp.sin_val = y_ff;  end
         2'd1: begin rsp.cos_val = -y_ff; rsp.sin_val = x_ff;  end
         2'd2: begin rsp.cos_val = -x_ff; rsp.sin_val = -y_ff; end
         default: begin rsp.cos_val = y_ff; rsp.sin_val = -x_ff; end
      endcase
   end
   assign rsp.done = done_ff;

endmodule

// ----- hdl/uv_sphere_vertex_generator.sv -----
// top level: sequencer, product stage and bounding box of the sphere vertex generator
// sequence from accept to rsp_valid: four serial 41-bit divisions and two 20-step cordic
//   runs, then the x multiply, the z multiply and the box update, one after the other
// req_ready is low while an item is in work, so a new item waits until the last is done
// an out-of-range item skips the arithmetic and gives its result in the cycle after accept
// reset: synchronous active high; resolution returns to 16 and the box to empty
module uv_sphere_vertex_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [7:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [6:0]         req_band,
   input  logic [8:0]         req_column,
   input  logic               req_upper_ring,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [15:0] rsp_pos_z,
   output logic signed [15:0] rsp_tex_u,
   output logic [14:0]        rsp_tex_v,
   output logic signed [15:0] rsp_box_min_x,
   output logic signed [15:0] rsp_box_min_y,
   output logic signed [15:0] rsp_box_min_z,
   output logic signed [15:0] rsp_box_max_x,
   output logic signed [15:0] rsp_box_max_y,
   output logic signed [15:0] rsp_box_max_z,
   output logic               rsp_index_error
);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_DIV_LT = 11'b00000000010,
      ST_COR_LT = 11'b00000000100,
      ST_DIV_LN = 11'b00000001000,
      ST_COR_LN = 11'b00000010000,
      ST_DIV_U  = 11'b00000100000,
      ST_DIV_V  = 11'b00001000000,
      ST_MUL_X  = 11'b00010000000,
      ST_MUL_Z  = 11'b00100000000,
      ST_BOX    = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0]  res_reg_ff;
   logic [8:0]  res;
   logic [7:0]  ring_ff, ring_in;
   logic [8:0]  col_ff, col_in;
   logic        rst_ff, rst_in;
   logic        wait_ff, wait_in;
   logic signed [33:0] cl_ff, cl_in, co_ff, co_in, so_ff, so_in;
   logic signed [15:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [15:0] tu_ff, tu_in;
   logic [14:0] tv_ff, tv_in;
   logic        err_ff, err_in;
   logic signed [15:0] lo_ff [3];
   logic signed [15:0] hi_ff [3];
   logic signed [15:0] lo_in [3];
   logic signed [15:0] hi_in [3];
   logic signed [67:0] prod;
   logic signed [33:0] mul_a;
   logic signed [15:0] prod_r;
   logic signed [15:0] sl_r;
   logic        bad;
   logic [40:0] phase_div;

   uvsg_pkg::div_req_type    dreq;
   uvsg_pkg::div_rsp_type    drsp;
   uvsg_pkg::cordic_req_type creq;
   uvsg_pkg::cordic_rsp_type crsp;

   uvsg_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));
   uvsg_cordic  u_cor (.clock(clock), .reset(reset), .req(creq), .rsp(crsp));

   // resolution register
   always_ff @(posedge clock) begin
      if (reset) res_reg_ff <= 8'd16;
      else if (csr_write_enable) res_reg_ff <= csr_write_data;
   end

   assign res = {1'b0, res_reg_ff} + {8'd0, res_reg_ff[0]};
   assign bad = ({2'b00, req_band} >= {1'b0, res[8:1]}) || (req_column > res);

   // round to nearest then saturate a q60 or q30 value to q1.15
   function automatic logic signed [15:0] rnd_sat(input logic signed [67:0] v,
                                                  input logic [5:0] s);
      logic signed [67:0] r;
      r = (v + (68'sd1 <<< (s - 6'd1))) >>> s;
      if (r > 68'sd32767) return uvsg_pkg::QMax;
      if (r < -68'sd32768) return uvsg_pkg::QMin;
      return r[15:0];
   endfunction

   assign mul_a  = state_ff == ST_MUL_Z ? -cl_ff : cl_ff;
   assign prod   = mul_a * (state_ff == ST_MUL_Z ? co_ff : so_ff);
   assign prod_r = rnd_sat(prod, 6'd45);
   assign sl_r   = rnd_sat(68'(crsp.sin_val), 6'd15);
   assign phase_div = drsp.quotient;

   // sequencer
   always_comb begin
      state_in = state_ff;
      ring_in = ring_ff; col_in = col_ff; rst_in = rst_ff; wait_in = 1'b0;
      cl_in = cl_ff; co_in = co_ff; so_in = so_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      tu_in = tu_ff; tv_in = tv_ff; err_in = err_ff;
      dreq = '0;
      creq = '0;
      for (int a = 0; a < 3; a++) begin
         lo_in[a] = lo_ff[a];
         hi_in[a] = hi_ff[a];
      end
      dreq.divisor = res;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ring_in = {1'b0, req_band} + {7'd0, req_upper_ring};
               col_in  = req_column;
               rst_in  = req_restart;
               err_in  = bad;
               if (bad) begin
                  px_in = '0; py_in = '0; pz_in = '0; tu_in = '0; tv_in = '0;
                  state_in = ST_OUT;
               end else begin
                  dreq.start    = 1'b1;
                  dreq.dividend = {1'b0, {1'b0, req_band} + {7'd0, req_upper_ring},
                                   32'd0} + {32'd0, res[8:1]};
                  state_in = ST_DIV_LT;
               end
            end
         end
         ST_DIV_LT: if (drsp.done) begin
            creq.start = 1'b1;
            creq.phase = phase_div[31:0] - 32'h4000_0000;
            state_in = ST_COR_LT;
         end
         ST_COR_LT: if (crsp.done) begin
            cl_in = crsp.cos_val;
            py_in = sl_r;
            dreq.start    = 1'b1;
            dreq.dividend = {col_ff, 32'd0} + {32'd0, res[8:1]};
            state_in = ST_DIV_LN;
         end
         ST_DIV_LN: if (drsp.done) begin
            creq.start = 1'b1;
            creq.phase = phase_div[31:0];
            state_in = ST_COR_LN;
         end
         ST_COR_LN: if (crsp.done) begin
            co_in = crsp.cos_val;
            so_in = crsp.sin_val;
            dreq.start    = 1'b1;
            dreq.dividend = {17'd0, col_ff, 15'd0} + {32'd0, res[8:1]};
            state_in = ST_DIV_U;
         end
         ST_DIV_U: if (drsp.done) begin
            tu_in = -$signed(phase_div[15:0]);
            dreq.start    = 1'b1;
            dreq.dividend = {17'd0, ring_ff, 16'd0} + {32'd0, res[8:1]};
            state_in = ST_DIV_V;
         end
         ST_DIV_V: if (drsp.done) begin
            tv_in = (phase_div > 41'd32767) ? 15'h7fff : phase_div[14:0];
            state_in = ST_MUL_X;
         end
         ST_MUL_X: begin
            px_in = prod_r;
            state_in = ST_MUL_Z;
         end
         ST_MUL_Z: begin
            pz_in = prod_r;
            state_in = ST_BOX;
         end
         ST_BOX: begin
            if (rst_ff) begin
               for (int a = 0; a < 3; a++) begin
                  lo_in[a] = uvsg_pkg::QMax;
                  hi_in[a] = uvsg_pkg::QMin;
               end
            end
            if (px_ff < lo_in[0]) lo_in[0] = px_ff;
            if (py_ff < lo_in[1]) lo_in[1] = py_ff;
            if (pz_ff < lo_in[2]) lo_in[2] = pz_ff;
            if (px_ff > hi_in[0]) hi_in[0] = px_ff;
            if (py_ff > hi_in[1]) hi_in[1] = py_ff;
            if (pz_ff > hi_in[2]) hi_in[2] = pz_ff;
            state_in = ST_OUT;
         end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            lo_ff[a] <= uvsg_pkg::QMax;
            hi_ff[a] <= uvsg_pkg::QMin;
         end
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         for (int a = 0; a < 3; a++) begin
            lo_ff[a] <= lo_in[a];
            hi_ff[a] <= hi_in[a];
         end
      end
      ring_ff <= ring_in; col_ff <= col_in; rst_ff <= rst_in;
      cl_ff <= cl_in; co_ff <= co_in; so_ff <= so_in;
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      tu_ff <= tu_in; tv_ff <= tv_in; err_ff <= err_in;
   end

   // outputs
   assign req_ready       = (state_ff == ST_IDLE) && !wait_ff;
   assign rsp_valid       = state_ff == ST_OUT;
   assign rsp_pos_x       = px_ff;
   assign rsp_pos_y       = py_ff;
   assign rsp_pos_z       = pz_ff;
   assign rsp_tex_u       = tu_ff;
   assign rsp_tex_v       = tv_ff;
   assign rsp_box_min_x   = lo_ff[0];
   assign rsp_box_min_y   = lo_ff[1];
   assign rsp_box_min_z   = lo_ff[2];
   assign rsp_box_max_x   = hi_ff[0];
   assign rsp_box_max_y   = hi_ff[1];
   assign rsp_box_max_z   = hi_ff[2];
   assign rsp_index_error = err_ff;

   // no new item while a result waits
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("ready while result pending");
   // an erroring item leaves the box untouched (checked on min x)
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |-> (lo_ff[0] == $past(lo_ff[0])))
      else $error("box changed on index error");
   // a valid box keeps min not above max for y
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_index_error) |-> (rsp_box_min_y <= rsp_box_max_y))
      else $error("box inverted");

endmodule
